@@ src/stt_pkg.sv @@
// Shared types, character codes and keyword tables for the source text tokenizer.
`default_nettype none
package stt_pkg;

  localparam int unsigned MANTISSA_BITS_DEFAULT = 48;
  localparam int unsigned CHAR_W                = 8;
  localparam int unsigned WORD_W                = 48;
  localparam int unsigned SCALE_W               = 5;
  localparam logic [SCALE_W-1:0] SCALE_MAX      = 5'd31;
  localparam int unsigned QUEUE_DEPTH           = 4;

  typedef enum logic [3:0] {
    KIND_EOF    = 4'd0,
    KIND_DEF    = 4'd1,
    KIND_EXTERN = 4'd2,
    KIND_IF     = 4'd3,
    KIND_THEN   = 4'd4,
    KIND_ELSE   = 4'd5,
    KIND_FOR    = 4'd6,
    KIND_IN     = 4'd7,
    KIND_IDENT  = 4'd8,
    KIND_NUMBER = 4'd9,
    KIND_STRING = 4'd10,
    KIND_SINGLE = 4'd11,
    KIND_TEXT   = 4'd12
  } kind_t;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_WORD    = 5'b00010,
    MODE_NUMBER  = 5'b00100,
    MODE_COMMENT = 5'b01000,
    MODE_STRING  = 5'b10000
  } mode_t;

  localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE    = 8'h22;
  localparam logic [CHAR_W-1:0] CH_DOT      = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_QUESTION = 8'h3F;

  localparam logic [WORD_W-1:0] KW_DEF    = 48'h0000_0064_6566;
  localparam logic [WORD_W-1:0] KW_EXTERN = 48'h6578_7465_726E;
  localparam logic [WORD_W-1:0] KW_IF     = 48'h0000_0000_6966;
  localparam logic [WORD_W-1:0] KW_THEN   = 48'h0000_7468_656E;
  localparam logic [WORD_W-1:0] KW_ELSE   = 48'h0000_656C_7365;
  localparam logic [WORD_W-1:0] KW_FOR    = 48'h0000_0066_6F72;
  localparam logic [WORD_W-1:0] KW_IN     = 48'h0000_0000_696E;

  function automatic logic is_letter(logic [CHAR_W-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(logic [CHAR_W-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [CHAR_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Keyword lookup on the collected word; anything else is an identifier.
  function automatic kind_t keyword_kind(logic [WORD_W-1:0] prefix, logic [2:0] len);
    kind_t k;
    k = KIND_IDENT;
    unique case (len)
      3'd2: begin
        if (prefix == KW_IF) k = KIND_IF;
        else if (prefix == KW_IN) k = KIND_IN;
      end
      3'd3: begin
        if (prefix == KW_DEF) k = KIND_DEF;
        else if (prefix == KW_FOR) k = KIND_FOR;
      end
      3'd4: begin
        if (prefix == KW_THEN) k = KIND_THEN;
        else if (prefix == KW_ELSE) k = KIND_ELSE;
      end
      3'd6: begin
        if (prefix == KW_EXTERN) k = KIND_EXTERN;
      end
      default: k = KIND_IDENT;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

@@ src/source_text_tokenizer.sv @@
// Top level of the source text tokenizer: lexer state, token building and result queue.
//
// Input channel s_axis carries one source byte per request in tdata; tuser set
// marks end of input instead of a byte. Output channel m_axis carries one token
// or pass-through character per request: tuser holds the kind, tdata the char
// code, mantissa, scale and the overflow and unterminated flags, tlast marks the
// final result caused by one input byte.
// Each byte is classified and folded into the lexer state in the cycle it is
// accepted; its results enter a four-entry result queue at that edge and are
// offered on m_axis from the next cycle.
// Throughput is one byte per cycle while each byte yields at most one result and the receiver does not stall.
// A byte that closes a token and also yields a result of its own, or end of input
// closing a token, yields two results, which leave the output port one at a time;
// the queue absorbs this; s_axis_tready drops only while three or more results wait.
// When the receiver stalls, queued results hold and input is taken while at most
// two results wait. Synchronous reset empties the queue and returns the lexer to
// idle with all number and word state cleared.
`default_nettype none
module source_text_tokenizer #(
  parameter int unsigned MANTISSA_BITS = stt_pkg::MANTISSA_BITS_DEFAULT,
  localparam int unsigned PAYLOAD_W = stt_pkg::CHAR_W + MANTISSA_BITS + stt_pkg::SCALE_W + 2,
  localparam int unsigned DATA_W    = ((PAYLOAD_W + 7) / 8) * 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_axis_tvalid,
  output      logic                     s_axis_tready,
  input  wire logic [7:0]               s_axis_tdata,  // ch
  input  wire logic                     s_axis_tuser,  // end_of_input
  output      logic                     m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // char_code, mantissa, scale, overflow, unterminated, zero padding
  output      logic [DATA_W-1:0]        m_axis_tdata,
  output      logic [3:0]               m_axis_tuser,  // kind
  output      logic                     m_axis_tlast
);

  localparam int unsigned PTR_W     = $clog2(stt_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W     = $clog2(stt_pkg::QUEUE_DEPTH + 1);

  typedef struct packed {
    stt_pkg::kind_t                 kind;
    logic [stt_pkg::CHAR_W-1:0]     code;
    logic [MANTISSA_BITS-1:0]       mant;
    logic [stt_pkg::SCALE_W-1:0]    scale;
    logic                           ovf;
    logic                           unt;
    logic                           last;
  } res_t;

  typedef struct packed {
    logic [MANTISSA_BITS-1:0]       value;
    logic [stt_pkg::SCALE_W-1:0]    frac;
    logic [1:0]                     dots;
    logic                           sat;
  } num_t;

  // One digit or dot folded into a number. Ten times the value plus the digit
  // overflows exactly when it no longer fits the mantissa width.
  function automatic num_t add_num(num_t s, logic [stt_pkg::CHAR_W-1:0] c);
    logic [MANTISSA_BITS+3:0] wide;
    logic [MANTISSA_BITS+3:0] prod;
    num_t r;
    r    = s;
    wide = {4'b0, s.value};
    prod = (wide << 3) + (wide << 1) + {{MANTISSA_BITS{1'b0}}, c[3:0]};
    priority if (c == stt_pkg::CH_DOT) begin
      if (s.dots < 2'd2) r.dots = s.dots + 2'd1;
    end else if (s.dots < 2'd2) begin
      priority if (s.dots == 2'd1 && s.frac >= stt_pkg::SCALE_MAX) begin
        r.sat = 1'b1;
      end else if (prod[MANTISSA_BITS+3:MANTISSA_BITS] != 4'd0) begin
        r.sat = 1'b1;
        if (s.dots == 2'd0) r.value = '1;
      end else begin
        r.value = prod[MANTISSA_BITS-1:0];
        if (s.dots == 2'd1) r.frac = s.frac + 5'd1;
      end
    end else begin
      // Digits after a second dot leave the number as it is.
      r = s;
    end
    return r;
  endfunction

  stt_pkg::mode_t               mode, mode_next;
  logic [stt_pkg::WORD_W-1:0]   word_prefix, word_prefix_next;
  logic [2:0]                   word_length, word_length_next;
  num_t                         num, num_next;

  res_t                         queue [stt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]             wr_ptr, rd_ptr;
  logic [CNT_W-1:0]             cnt, cnt_next;

  logic [stt_pkg::CHAR_W-1:0]   c;
  logic                         accept, pop;

  // Idle-mode handling of the current byte.
  logic                         ic_v;
  res_t                         ic_res;
  stt_pkg::mode_t               ic_mode;
  logic [stt_pkg::WORD_W-1:0]   ic_prefix;
  logic [2:0]                   ic_len;
  num_t                         ic_num;

  logic                         pre_v, post_v;
  res_t                         pre_res, post_res;
  res_t                         r0, r1;
  logic [1:0]                   n_res;

  assign c      = s_axis_tdata;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign pop    = m_axis_tvalid && m_axis_tready;

  always_comb begin
    ic_v      = 1'b0;
    ic_res    = '0;
    ic_mode   = stt_pkg::MODE_IDLE;
    ic_prefix = word_prefix;
    ic_len    = word_length;
    ic_num    = num;
    priority if (stt_pkg::is_space(c)) begin
      ic_mode = stt_pkg::MODE_IDLE;
    end else if (stt_pkg::is_letter(c)) begin
      ic_mode     = stt_pkg::MODE_WORD;
      ic_prefix   = {{(stt_pkg::WORD_W - stt_pkg::CHAR_W){1'b0}}, c};
      ic_len      = 3'd1;
      ic_v        = 1'b1;
      ic_res.kind = stt_pkg::KIND_TEXT;
      ic_res.code = c;
    end else if (stt_pkg::is_digit(c) || c == stt_pkg::CH_DOT) begin
      ic_mode = stt_pkg::MODE_NUMBER;
      ic_num  = add_num('0, c);
    end else if (c == stt_pkg::CH_QUESTION) begin
      ic_mode = stt_pkg::MODE_COMMENT;
    end else if (c == stt_pkg::CH_QUOTE) begin
      ic_mode = stt_pkg::MODE_STRING;
    end else begin
      ic_v        = 1'b1;
      ic_res.kind = stt_pkg::KIND_SINGLE;
      ic_res.code = c;
    end
  end

  always_comb begin
    mode_next        = mode;
    word_prefix_next = word_prefix;
    word_length_next = word_length;
    num_next         = num;
    pre_v            = 1'b0;
    pre_res          = '0;
    post_v           = 1'b0;
    post_res         = '0;
    if (s_axis_tuser) begin
      // Close whatever is open, then report end of input.
      unique case (mode)
        stt_pkg::MODE_WORD: begin
          pre_v        = 1'b1;
          pre_res.kind = stt_pkg::keyword_kind(word_prefix, word_length);
        end
        stt_pkg::MODE_NUMBER: begin
          pre_v         = 1'b1;
          pre_res.kind  = stt_pkg::KIND_NUMBER;
          pre_res.mant  = num.value;
          pre_res.scale = num.frac;
          pre_res.ovf   = num.sat;
        end
        stt_pkg::MODE_STRING: begin
          pre_v        = 1'b1;
          pre_res.kind = stt_pkg::KIND_STRING;
          pre_res.unt  = 1'b1;
        end
        default: pre_v = 1'b0;
      endcase
      post_v        = 1'b1;
      post_res.kind = stt_pkg::KIND_EOF;
      mode_next     = stt_pkg::MODE_IDLE;
    end else begin
      unique case (mode)
        stt_pkg::MODE_WORD: begin
          if (stt_pkg::is_letter(c) || stt_pkg::is_digit(c)) begin
            if (word_length < 3'd7) begin
              word_prefix_next = {word_prefix[stt_pkg::WORD_W-stt_pkg::CHAR_W-1:0], c};
              word_length_next = word_length + 3'd1;
            end
            post_v        = 1'b1;
            post_res.kind = stt_pkg::KIND_TEXT;
            post_res.code = c;
          end else begin
            pre_v            = 1'b1;
            pre_res.kind     = stt_pkg::keyword_kind(word_prefix, word_length);
            post_v           = ic_v;
            post_res         = ic_res;
            mode_next        = ic_mode;
            word_prefix_next = ic_prefix;
            word_length_next = ic_len;
            num_next         = ic_num;
          end
        end
        stt_pkg::MODE_NUMBER: begin
          if (stt_pkg::is_digit(c) || c == stt_pkg::CH_DOT) begin
            num_next = add_num(num, c);
          end else begin
            pre_v            = 1'b1;
            pre_res.kind     = stt_pkg::KIND_NUMBER;
            pre_res.mant     = num.value;
            pre_res.scale    = num.frac;
            pre_res.ovf      = num.sat;
            post_v           = ic_v;
            post_res         = ic_res;
            mode_next        = ic_mode;
            word_prefix_next = ic_prefix;
            word_length_next = ic_len;
            num_next         = ic_num;
          end
        end
        stt_pkg::MODE_COMMENT: begin
          if (c == stt_pkg::CH_LF || c == stt_pkg::CH_CR) mode_next = stt_pkg::MODE_IDLE;
        end
        stt_pkg::MODE_STRING: begin
          post_v = 1'b1;
          if (c == stt_pkg::CH_QUOTE) begin
            post_res.kind = stt_pkg::KIND_STRING;
            mode_next     = stt_pkg::MODE_IDLE;
          end else begin
            post_res.kind = stt_pkg::KIND_TEXT;
            post_res.code = c;
          end
        end
        default: begin
          post_v           = ic_v;
          post_res         = ic_res;
          mode_next        = ic_mode;
          word_prefix_next = ic_prefix;
          word_length_next = ic_len;
          num_next         = ic_num;
        end
      endcase
    end
  end

  // Order the results of this byte and flag the final one.
  always_comb begin
    r0 = post_res;
    r1 = post_res;
    n_res = {1'b0, post_v};
    if (pre_v) begin
      r0    = pre_res;
      n_res = post_v ? 2'd2 : 2'd1;
    end
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  assign s_axis_tready = cnt <= CNT_W'(stt_pkg::QUEUE_DEPTH - 2);
  assign cnt_next      = cnt + (accept ? CNT_W'(n_res) : '0) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= stt_pkg::MODE_IDLE;
      word_prefix <= '0;
      word_length <= '0;
      num         <= '0;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      cnt         <= '0;
    end else begin
      if (accept) begin
        mode        <= mode_next;
        word_prefix <= word_prefix_next;
        word_length <= word_length_next;
        num         <= num_next;
        wr_ptr      <= wr_ptr + PTR_W'(n_res);
      end
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) queue[wr_ptr] <= r0;
    if (accept && n_res == 2'd2) queue[wr_ptr + PTR_W'(1)] <= r1;
  end

  assign m_axis_tvalid = cnt != '0;
  assign m_axis_tuser  = queue[rd_ptr].kind;
  assign m_axis_tlast  = queue[rd_ptr].last;
  assign m_axis_tdata  = DATA_W'({queue[rd_ptr].unt, queue[rd_ptr].ovf, queue[rd_ptr].scale,
                                  queue[rd_ptr].mant, queue[rd_ptr].code});

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the source text tokenizer with a token scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int unsigned MANT_W     = stt_pkg::MANTISSA_BITS_DEFAULT;
  localparam int unsigned RES_BITS   = 8 + MANT_W + 5 + 1 + 1;
  localparam int unsigned DATA_W     = ((RES_BITS + 7) / 8) * 8;
  localparam int unsigned QUIET_MAX  = 3000;
  localparam int unsigned PHASE_ITEMS = 150;

  typedef struct packed {
    stt_pkg::kind_t     kind;
    logic [7:0]         code;
    logic [MANT_W-1:0]  mant;
    logic [4:0]         scale;
    logic               ovf;
    logic               unterm;
    logic               last;
  } token_t;

  // Tracks the lexer state for every accepted request and holds the tokens it must emit.
  class token_scoreboard;
    token_t          expected_q[$];
    token_t          held;
    bit              have_held;
    int              errors;
    stt_pkg::mode_t  lex_mode;
    logic [47:0]     word_bytes;
    logic [2:0]      word_len;
    logic [63:0]     num_value;
    logic [4:0]      frac_digits;
    logic [1:0]      dots_seen;
    logic            num_sat;

    function new();
      lex_mode    = stt_pkg::MODE_IDLE;
      word_bytes  = '0;
      word_len    = '0;
      num_value   = '0;
      frac_digits = '0;
      dots_seen   = '0;
      num_sat     = 1'b0;
      have_held   = 1'b0;
      errors      = 0;
    endfunction

    function bit letter_char(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit digit_char(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit blank_char(logic [7:0] c);
      return c == stt_pkg::CH_SPACE || (c >= stt_pkg::CH_TAB && c <= stt_pkg::CH_CR);
    endfunction

    // The previous token of this request is not the final one, so it goes out with last low.
    function void emit_token(stt_pkg::kind_t kind, logic [7:0] code, logic [MANT_W-1:0] mant,
                             logic [4:0] scale, logic ovf, logic unterm);
      if (have_held)
        expected_q.push_back(held);
      held = '{kind, code, mant, scale, ovf, unterm, 1'b0};
      have_held = 1'b1;
    endfunction

    function void close_word();
      logic [47:0] w_def, w_extern, w_if, w_then, w_else, w_for, w_in;
      stt_pkg::kind_t kind;
      w_def = "def";   w_extern = "extern"; w_if = "if";  w_then = "then";
      w_else = "else"; w_for = "for";       w_in = "in";
      kind = stt_pkg::KIND_IDENT;
      if (word_len == 3'd3 && word_bytes == w_def)         kind = stt_pkg::KIND_DEF;
      else if (word_len == 3'd6 && word_bytes == w_extern) kind = stt_pkg::KIND_EXTERN;
      else if (word_len == 3'd2 && word_bytes == w_if)     kind = stt_pkg::KIND_IF;
      else if (word_len == 3'd4 && word_bytes == w_then)   kind = stt_pkg::KIND_THEN;
      else if (word_len == 3'd4 && word_bytes == w_else)   kind = stt_pkg::KIND_ELSE;
      else if (word_len == 3'd3 && word_bytes == w_for)    kind = stt_pkg::KIND_FOR;
      else if (word_len == 3'd2 && word_bytes == w_in)     kind = stt_pkg::KIND_IN;
      emit_token(kind, '0, '0, '0, 1'b0, 1'b0);
      lex_mode = stt_pkg::MODE_IDLE;
    endfunction

    function void close_number();
      emit_token(stt_pkg::KIND_NUMBER, '0, num_value[MANT_W-1:0], frac_digits, num_sat, 1'b0);
      lex_mode = stt_pkg::MODE_IDLE;
    endfunction

    // Only the first seven bytes of a word shift in; a word that long is never a keyword.
    function void word_char(logic [7:0] c);
      if (word_len < 3'd7) begin
        word_bytes = {word_bytes[39:0], c};
        word_len   = word_len + 3'd1;
      end
      emit_token(stt_pkg::KIND_TEXT, c, '0, '0, 1'b0, 1'b0);
    endfunction

    function void number_char(logic [7:0] c);
      logic [63:0] top, d;
      top = (64'd1 << MANT_W) - 64'd1;
      if (c == stt_pkg::CH_DOT) begin
        if (dots_seen < 2'd2)
          dots_seen = dots_seen + 2'd1;
        return;
      end
      if (dots_seen >= 2'd2)
        return;
      d = 64'(c - "0");
      if (dots_seen == 2'd1 && frac_digits >= 5'd31) begin
        num_sat = 1'b1;
        return;
      end
      if (num_value > (top - d) / 64'd10) begin
        num_sat = 1'b1;
        if (dots_seen == 2'd0)
          num_value = top;
        return;
      end
      num_value = num_value * 64'd10 + d;
      if (dots_seen == 2'd1)
        frac_digits = frac_digits + 5'd1;
    endfunction

    function void idle_char(logic [7:0] c);
      lex_mode = stt_pkg::MODE_IDLE;
      if (blank_char(c))
        return;
      if (letter_char(c)) begin
        lex_mode   = stt_pkg::MODE_WORD;
        word_bytes = '0;
        word_len   = '0;
        word_char(c);
      end else if (digit_char(c) || c == stt_pkg::CH_DOT) begin
        lex_mode    = stt_pkg::MODE_NUMBER;
        num_value   = '0;
        frac_digits = '0;
        dots_seen   = '0;
        num_sat     = 1'b0;
        number_char(c);
      end else if (c == stt_pkg::CH_QUESTION) begin
        lex_mode = stt_pkg::MODE_COMMENT;
      end else if (c == stt_pkg::CH_QUOTE) begin
        lex_mode = stt_pkg::MODE_STRING;
      end else begin
        emit_token(stt_pkg::KIND_SINGLE, c, '0, '0, 1'b0, 1'b0);
      end
    endfunction

    // Returns how many tokens the accepted request produces.
    function int note_request(logic [7:0] c, logic eoi);
      int n0;
      n0 = expected_q.size() + (have_held ? 1 : 0);
      if (eoi) begin
        case (lex_mode)
          stt_pkg::MODE_WORD:   close_word();
          stt_pkg::MODE_NUMBER: close_number();
          stt_pkg::MODE_STRING: emit_token(stt_pkg::KIND_STRING, '0, '0, '0, 1'b0, 1'b1);
          default: ;
        endcase
        emit_token(stt_pkg::KIND_EOF, '0, '0, '0, 1'b0, 1'b0);
        lex_mode = stt_pkg::MODE_IDLE;
      end else begin
        case (lex_mode)
          stt_pkg::MODE_WORD: begin
            if (letter_char(c) || digit_char(c)) word_char(c);
            else begin
              close_word();
              idle_char(c);
            end
          end
          stt_pkg::MODE_NUMBER: begin
            if (digit_char(c) || c == stt_pkg::CH_DOT) number_char(c);
            else begin
              close_number();
              idle_char(c);
            end
          end
          stt_pkg::MODE_COMMENT: begin
            if (c == stt_pkg::CH_LF || c == stt_pkg::CH_CR) lex_mode = stt_pkg::MODE_IDLE;
          end
          stt_pkg::MODE_STRING: begin
            if (c == stt_pkg::CH_QUOTE) begin
              emit_token(stt_pkg::KIND_STRING, '0, '0, '0, 1'b0, 1'b0);
              lex_mode = stt_pkg::MODE_IDLE;
            end else begin
              emit_token(stt_pkg::KIND_TEXT, c, '0, '0, 1'b0, 1'b0);
            end
          end
          default: idle_char(c);
        endcase
      end
      if (have_held) begin
        held.last = 1'b1;
        expected_q.push_back(held);
        have_held = 1'b0;
      end
      return expected_q.size() - n0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(stt_pkg::kind_t kind, logic [7:0] code, logic [MANT_W-1:0] mant,
                      logic [4:0] scale, logic ovf, logic unterm, logic last);
      token_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("kind %0d arrived with nothing expected", kind));
        return;
      end
      want = expected_q.pop_front();
      if (kind !== want.kind)
        report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
      if (code !== want.code)
        report_mismatch($sformatf("char_code %0h, expected %0h", code, want.code));
      if (mant !== want.mant)
        report_mismatch($sformatf("mantissa %0d, expected %0d", mant, want.mant));
      if (scale !== want.scale)
        report_mismatch($sformatf("scale %0d, expected %0d", scale, want.scale));
      if (ovf !== want.ovf)
        report_mismatch($sformatf("overflow %0b, expected %0b", ovf, want.ovf));
      if (unterm !== want.unterm)
        report_mismatch($sformatf("unterminated %0b, expected %0b", unterm, want.unterm));
      if (last !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = 8'h00;  // ch
  logic              s_axis_tuser = 1'b0;   // end_of_input
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // char_code, mantissa, scale, overflow, unterminated, zero padding
  logic [DATA_W-1:0] m_axis_tdata;
  logic [3:0]        m_axis_tuser;          // kind
  logic              m_axis_tlast;

  token_scoreboard sb = new();
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int token_items = 0;
  int quiet_cycles = 0;

  source_text_tokenizer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(stt_pkg::kind_t'(m_axis_tuser), m_axis_tdata[7:0],
                        m_axis_tdata[8 +: MANT_W], m_axis_tdata[8 + MANT_W +: 5],
                        m_axis_tdata[8 + MANT_W + 5], m_axis_tdata[8 + MANT_W + 6],
                        m_axis_tlast);
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Holds one request on the bus until the tokenizer takes it.
  task automatic send(input logic [7:0] c, input logic eoi);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= eoi;
    do @(posedge clk); while (!s_axis_tready);
    void'(sb.note_request(c, eoi));
    token_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send(s[i], 1'b0);
  endtask

  function automatic logic [7:0] any_letter();
    int r;
    r = $urandom_range(51);
    return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  task automatic send_number();
    int n_int, n_frac;
    bit long_zero;
    n_int = ($urandom_range(9) == 0) ? $urandom_range(13, 20) : $urandom_range(0, 4);
    for (int i = 0; i < n_int; i++)
      send(any_digit(), 1'b0);
    if (n_int == 0 || $urandom_range(2) == 0) begin
      send(stt_pkg::CH_DOT, 1'b0);
      long_zero = ($urandom_range(5) == 0);
      n_frac = long_zero ? $urandom_range(28, 36) : $urandom_range(0, 5);
      for (int i = 0; i < n_frac; i++)
        send((long_zero && $urandom_range(7) != 0) ? 8'("0") : any_digit(), 1'b0);
      // A second dot switches off everything that follows in this number.
      if ($urandom_range(7) == 0) begin
        send(stt_pkg::CH_DOT, 1'b0);
        repeat ($urandom_range(0, 3)) send(any_digit(), 1'b0);
        if ($urandom_range(1) == 0) send(stt_pkg::CH_DOT, 1'b0);
      end
    end
  endtask

  task automatic send_token();
    string keywords[7] = '{"def", "extern", "if", "then", "else", "for", "in"};
    string ops = "+-*/<>=();,";
    logic [7:0] c;
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) begin
      send_text(keywords[$urandom_range(6)]);
      if ($urandom_range(9) < 6) send(stt_pkg::CH_SPACE, 1'b0);
    end else if (pick < 40) begin
      send(any_letter(), 1'b0);
      repeat ($urandom_range(0, 9))
        send(($urandom_range(2) == 0) ? any_digit() : any_letter(), 1'b0);
      if ($urandom_range(9) < 6) send(stt_pkg::CH_SPACE, 1'b0);
    end else if (pick < 58) begin
      send_number();
      if ($urandom_range(9) < 6) send(stt_pkg::CH_SPACE, 1'b0);
    end else if (pick < 68) begin
      send(stt_pkg::CH_QUOTE, 1'b0);
      repeat ($urandom_range(0, 8)) begin
        c = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(32, 126));
        if (c == stt_pkg::CH_QUOTE) c = stt_pkg::CH_SPACE;
        send(c, 1'b0);
      end
      if ($urandom_range(19) != 0) send(stt_pkg::CH_QUOTE, 1'b0);
    end else if (pick < 73) begin
      send(stt_pkg::CH_QUESTION, 1'b0);
      repeat ($urandom_range(0, 6)) begin
        c = 8'($urandom_range(255));
        if (c == stt_pkg::CH_LF || c == stt_pkg::CH_CR) c = stt_pkg::CH_QUESTION;
        send(c, 1'b0);
      end
      if ($urandom_range(9) != 0)
        send(($urandom_range(1) == 0) ? stt_pkg::CH_LF : stt_pkg::CH_CR, 1'b0);
    end else if (pick < 85) begin
      send(ops[$urandom_range(ops.len() - 1)], 1'b0);
    end else if (pick < 93) begin
      send(($urandom_range(1) == 0) ? stt_pkg::CH_SPACE : 8'($urandom_range(9, 13)), 1'b0);
    end else if (pick < 97) begin
      send(8'($urandom_range(255)), 1'b0);
    end else begin
      send(8'($urandom_range(255)), 1'b1);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty string, lone dot, second dot, comment to CR, byte extremes,
    // a keyword closed by a single char, and a string cut off by end of input.
    send_text("\"\"");
    send_text(".+");
    send_text("1.2.3;");
    send_text("?z");
    send(stt_pkg::CH_CR, 1'b0);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send_text("if(");
    send_text("\"a");
    send(8'hA5, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
        default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
      endcase
      token_items = 0;
      while (token_items < PHASE_ITEMS)
        send_token();
    end
    send(8'h00, 1'b1);
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
src/stt_pkg.sv
src/source_text_tokenizer.sv
tb/sv/tb_top.sv
